### src/thr_pkg.sv
// ----------------------------------------------------------------------------
// thr_pkg: shared constants and helpers of the telemetry history recorder
// Holds the record layout, the fixed constants and the divide-by-constant helpers.
// ----------------------------------------------------------------------------
package thr_pkg;

  localparam int unsigned RecordBytes = 22;
  localparam int unsigned RecordW     = RecordBytes * 8;
  // Bytes 1 to 18 of a record are packed and scaled from the input word.
  localparam int unsigned BodyW       = 18 * 8;
  localparam int unsigned SecondsW    = 24;

  localparam logic [SecondsW-1:0] SecondsWrap   = 24'd16000000;
  localparam logic [7:0]          ErrorInterval = 8'd5;
  localparam logic [7:0]          AmbientOffset = 8'd50;
  localparam logic [7:0]          DumpByte0     = 8'd1;

  // Configuration register indexes.
  localparam logic [1:0] CfgNormalInterval = 2'd0;
  localparam logic [1:0] CfgSleepInterval  = 2'd1;
  localparam logic [1:0] CfgTicksPerRecord = 2'd2;

  // Bits of the mode flags.
  localparam int unsigned ModeErrorBit = 0;
  localparam int unsigned ModeSleepBit = 1;

  // Reciprocal multipliers: exact floor quotients for every 16-bit dividend.
  localparam logic [32:0] Div100Mul = 33'd83887;  // ceil(2^23 / 100)
  localparam logic [31:0] Div10Mul  = 32'd52429;  // ceil(2^19 / 10)

  function automatic logic [15:0] div100(input logic [15:0] x);
    logic [32:0] p;
    p = 33'(x) * Div100Mul;
    return {6'd0, p[32:23]};
  endfunction

  function automatic logic [15:0] div10(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * Div10Mul;
    return {3'd0, p[31:19]};
  endfunction

endpackage

### src/telemetry_history_recorder.sv
// ----------------------------------------------------------------------------
// telemetry_history_recorder: periodic telemetry record logger with error dump
// Packs a 22-byte record every ticks_per_record ticks, keeps it in a history
// ring and emits records at the active interval or as a full ring dump.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                    | Word
//  ---------+------------------------------+-------------------------------------
//  input    | in_valid_i / in_ready_o      | one system tick of telemetry + mode
//  output   | out_valid_o / out_ready_i    | one 22-byte record, is_dump, last
//  config   | cfg_valid_i / cfg_ready_o    | register index and 8-bit data
//
// A tick that emits nothing goes from SWrite back to idle, whether or not a
// record is stored, and passes through SEmit when the periodic word goes out.
// A dump adds SDRead to start the ring read and then streams one ring row per
// cycle from the ring's single read port while the output is not stalled.
// Reset clears all control state and the ring's row valid bits at once, so no
// clearing pass is needed. A stalled output holds the sequencer in place; the
// next tick is taken while the last word waits.
//
module telemetry_history_recorder #(
  parameter int unsigned RING_DEPTH = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  stack_temp_i,
  input  logic [8:0]                  processor_temp_i,
  input  logic signed [7:0]           ambient_temp_i,
  input  logic [15:0]                 fc_peak_current_i,
  input  logic [15:0]                 min_fc_volts_i,
  input  logic [15:0]                 battery_centivolts_i,
  input  logic [15:0]                 air_flow_tenths_i,
  input  logic [7:0]                  fuel_flow_i,
  input  logic [15:0]                 min_output_volts_i,
  input  logic [15:0]                 load_peak_current_i,
  input  logic [15:0]                 status_bytes_i,
  input  logic [1:0]                  mode_flags_i,

  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [63:0]                 record_low_o,
  output logic [63:0]                 record_mid_o,
  output logic [47:0]                 record_high_o,
  output logic                        is_dump_o,
  output logic                        last_o,

  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [7:0]                  cfg_data_i
);
  import thr_pkg::*;

  localparam int unsigned RowW = $clog2(RING_DEPTH);
  localparam logic [RowW-1:0] LastRow = RowW'(RING_DEPTH - 1);

  // Sequencer states.
  localparam logic [2:0] SIdle  = 3'd0;  // waiting for a tick
  localparam logic [2:0] SWrite = 3'd1;  // store the record, update the mode
  localparam logic [2:0] SEmit  = 3'd2;  // hand the periodic record out
  localparam logic [2:0] SDRead = 3'd3;  // first ring read of a dump
  localparam logic [2:0] SDOut  = 3'd4;  // stream dump rows, one per cycle unless stalled

  logic [2:0] state_d, state_q;

  // Configuration registers.
  logic [7:0] normal_int_q, sleep_int_q;
  logic [6:0] tpr_q;

  // Recorder state.
  logic [6:0]          tick_d, tick_q;
  logic [RowW-1:0]     write_row_d, write_row_q;
  logic [7:0]          act_int_d, act_int_q;
  logic [7:0]          rsw_d, rsw_q;
  logic [SecondsW-1:0] secs_d, secs_q;
  logic                dump_done_d, dump_done_q;

  // Per-tick context.
  logic                hit_d, hit_q;
  logic                dump_go_d, dump_go_q;
  logic [1:0]          mode_d, mode_q;
  logic [RecordW-1:0]  rec_d, rec_q;
  logic [RowW-1:0]     dump_row_d, dump_row_q;
  logic [RowW-1:0]     dump_cnt_d, dump_cnt_q;

  // Output register.
  logic                out_valid_d, out_valid_q;
  logic [RecordW-1:0]  out_rec_d, out_rec_q;
  logic                out_dump_d, out_dump_q;
  logic                out_last_d, out_last_q;
  logic                out_load;
  logic                out_free;

  // Datapath.
  logic                in_fire;
  logic [6:0]          tick_inc;
  logic [BodyW-1:0]    body;
  logic [SecondsW-1:0] secs_plus, secs_next;
  logic [7:0]          rsw_inc;
  logic                emit;
  logic                err_mode, sleep_mode;
  logic [RowW-1:0]     row_after_write;
  logic [RecordW-1:0]  rec_new;
  logic                ring_we, ring_re;
  logic [RecordW-1:0]  ring_rdata;

  assign in_ready_o  = (state_q == SIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  assign tick_inc   = tick_q + 7'd1;
  assign err_mode   = mode_q[ModeErrorBit];
  assign sleep_mode = mode_q[ModeSleepBit];

  // The seconds count steps before packing and wraps back to zero.
  assign secs_plus = secs_q + 24'd1;
  assign secs_next = (secs_plus == SecondsWrap) ? '0 : secs_plus;

  assign rsw_inc = rsw_q + 8'd1;
  assign emit    = hit_q && (rsw_inc >= act_int_q);

  assign row_after_write = !hit_q ? write_row_q :
                           (write_row_q == LastRow) ? '0 : write_row_q + RowW'(1);

  // Byte 0 carries the interval in force before this tick's mode update.
  assign rec_new = {secs_next, body, act_int_q};

  thr_pack u_pack (
    .clk_i                (clk_i),
    .load_i               (in_fire),
    .stack_temp_i         (stack_temp_i),
    .processor_temp_i     (processor_temp_i),
    .ambient_temp_i       (ambient_temp_i),
    .fc_peak_current_i    (fc_peak_current_i),
    .min_fc_volts_i       (min_fc_volts_i),
    .battery_centivolts_i (battery_centivolts_i),
    .air_flow_tenths_i    (air_flow_tenths_i),
    .fuel_flow_i          (fuel_flow_i),
    .min_output_volts_i   (min_output_volts_i),
    .load_peak_current_i  (load_peak_current_i),
    .status_bytes_i       (status_bytes_i),
    .body_o               (body)
  );

  thr_ring #(
    .Depth (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ring_we),
    .waddr_i (write_row_q),
    .wdata_i (rec_new),
    .re_i    (ring_re),
    .raddr_i (dump_row_q),
    .rdata_o (ring_rdata)
  );

  // Main sequencer. Each tick runs to completion before the next is taken.
  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    write_row_d = write_row_q;
    act_int_d   = act_int_q;
    rsw_d       = rsw_q;
    secs_d      = secs_q;
    dump_done_d = dump_done_q;
    hit_d       = hit_q;
    dump_go_d   = dump_go_q;
    mode_d      = mode_q;
    rec_d       = rec_q;
    dump_row_d  = dump_row_q;
    dump_cnt_d  = dump_cnt_q;
    ring_we     = 1'b0;
    ring_re     = 1'b0;
    out_load    = 1'b0;
    out_rec_d   = out_rec_q;
    out_dump_d  = out_dump_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      SIdle: begin
        if (in_fire) begin
          // A record is due when the wrapped tick count meets the period.
          hit_d     = (tick_inc == tpr_q);
          tick_d    = (tick_inc == tpr_q) ? '0 : tick_inc;
          mode_d    = mode_flags_i;
          dump_go_d = mode_flags_i[ModeErrorBit] && !mode_flags_i[ModeSleepBit] &&
                      !dump_done_q;
          state_d   = SWrite;
        end
      end

      SWrite: begin
        rec_d = rec_new;
        if (hit_q) begin
          ring_we     = 1'b1;
          secs_d      = secs_next;
          write_row_d = row_after_write;
          rsw_d       = emit ? '0 : rsw_inc;
        end
        if (err_mode && !sleep_mode) begin
          act_int_d   = ErrorInterval;
          dump_done_d = 1'b1;
        end else begin
          act_int_d   = sleep_mode ? sleep_int_q : normal_int_q;
          dump_done_d = 1'b0;
        end
        // A dump starts at the oldest row, the one the next write would take.
        dump_row_d = row_after_write;
        dump_cnt_d = '0;
        if (emit) begin
          state_d = SEmit;
        end else if (dump_go_q) begin
          state_d = SDRead;
        end else begin
          state_d = SIdle;
        end
      end

      SEmit: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_rec_d  = rec_q;
          out_dump_d = 1'b0;
          out_last_d = !dump_go_q;
          state_d    = dump_go_q ? SDRead : SIdle;
        end
      end

      SDRead: begin
        ring_re    = 1'b1;
        dump_row_d = (dump_row_q == LastRow) ? '0 : dump_row_q + RowW'(1);
        state_d    = SDOut;
      end

      SDOut: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_rec_d  = {ring_rdata[RecordW-1:8], DumpByte0};
          out_dump_d = 1'b1;
          out_last_d = (dump_cnt_q == LastRow);
          if (dump_cnt_q == LastRow) begin
            state_d = SIdle;
          end else begin
            // Fetch the next row while this one goes out.
            ring_re    = 1'b1;
            dump_row_d = (dump_row_q == LastRow) ? '0 : dump_row_q + RowW'(1);
            dump_cnt_d = dump_cnt_q + RowW'(1);
          end
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      normal_int_q <= 8'd1;
      sleep_int_q  <= 8'd60;
      tpr_q        <= 7'd100;
      tick_q       <= '0;
      write_row_q  <= '0;
      act_int_q    <= '0;
      rsw_q        <= '0;
      secs_q       <= '0;
      dump_done_q  <= 1'b0;
      hit_q        <= 1'b0;
      dump_go_q    <= 1'b0;
      mode_q       <= '0;
      dump_row_q   <= '0;
      dump_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      write_row_q <= write_row_d;
      act_int_q   <= act_int_d;
      rsw_q       <= rsw_d;
      secs_q      <= secs_d;
      dump_done_q <= dump_done_d;
      hit_q       <= hit_d;
      dump_go_q   <= dump_go_d;
      mode_q      <= mode_d;
      dump_row_q  <= dump_row_d;
      dump_cnt_q  <= dump_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgNormalInterval: normal_int_q <= cfg_data_i;
          CfgSleepInterval:  sleep_int_q  <= cfg_data_i;
          CfgTicksPerRecord: tpr_q        <= cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    rec_q      <= rec_d;
    out_rec_q  <= out_rec_d;
    out_dump_q <= out_dump_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign record_low_o  = out_rec_q[63:0];
  assign record_mid_o  = out_rec_q[127:64];
  assign record_high_o = out_rec_q[175:128];
  assign is_dump_o     = out_dump_q;
  assign last_o        = out_last_q;

endmodule

### src/thr_pack.sv
// ----------------------------------------------------------------------------
// thr_pack: record body packer
// Scales the telemetry of one tick and registers record bytes 1 to 18.
// ----------------------------------------------------------------------------
module thr_pack (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic [7:0]                stack_temp_i,
  input  logic [8:0]                processor_temp_i,
  input  logic signed [7:0]         ambient_temp_i,
  input  logic [15:0]               fc_peak_current_i,
  input  logic [15:0]               min_fc_volts_i,
  input  logic [15:0]               battery_centivolts_i,
  input  logic [15:0]               air_flow_tenths_i,
  input  logic [7:0]                fuel_flow_i,
  input  logic [15:0]               min_output_volts_i,
  input  logic [15:0]               load_peak_current_i,
  input  logic [15:0]               status_bytes_i,
  output logic [thr_pkg::BodyW-1:0] body_o
);
  import thr_pkg::*;

  logic [BodyW-1:0] body_d, body_q;

  // Byte 1 sits at the least significant end of the body.
  always_comb begin
    body_d = {status_bytes_i,
              div100(load_peak_current_i),
              div100(min_output_volts_i),
              fuel_flow_i,
              air_flow_tenths_i,
              battery_centivolts_i,
              div10(min_fc_volts_i),
              div100(fc_peak_current_i),
              $unsigned(ambient_temp_i) + AmbientOffset,
              processor_temp_i[8:1],
              stack_temp_i};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      body_q <= body_d;
    end
  end

  assign body_o = body_q;

endmodule

### src/thr_ring.sv
// ----------------------------------------------------------------------------
// thr_ring: history ring memory
// One write and one registered read port; rows never written read as zero.
// ----------------------------------------------------------------------------
module thr_ring #(
  parameter int unsigned Depth = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        we_i,
  input  logic [$clog2(Depth)-1:0]    waddr_i,
  input  logic [thr_pkg::RecordW-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [$clog2(Depth)-1:0]    raddr_i,
  output logic [thr_pkg::RecordW-1:0] rdata_o
);
  import thr_pkg::*;

  logic [RecordW-1:0] mem [Depth];
  logic [Depth-1:0]   row_valid_q;
  logic [RecordW-1:0] rdata_q;
  logic               rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (we_i) begin
        row_valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= row_valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

### src/thr_checker.sv
// ----------------------------------------------------------------------------
// thr_checker: port-level checks of the telemetry history recorder
// Watches the channels over time and is bound to the top level.
// ----------------------------------------------------------------------------
module thr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] record_low_o,
  input logic [47:0] record_high_o,
  input logic        is_dump_o
);
  import thr_pkg::*;

  // A word that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A taken tick drops the input ready, so ticks are never taken back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken in back-to-back cycles");

  // Dumped rows carry byte 0 forced to one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_dump_o |-> record_low_o[7:0] == DumpByte0)
    else $error("dump word without forced byte 0");

  // The seconds field never reaches its wrap value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> record_high_o[47:24] < SecondsWrap)
    else $error("seconds field out of range");

endmodule

bind telemetry_history_recorder thr_checker u_thr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .record_low_o  (record_low_o),
  .record_high_o (record_high_o),
  .is_dump_o     (is_dump_o)
);

### sim/tb_telemetry_history_recorder.sv
// ----------------------------------------------------------------------------
// tb_telemetry_history_recorder: self-checking testbench of the history recorder
// Drives system ticks with random idle gaps and output stalls, predicts every
// record word (periodic writes and ring dumps) in a scoreboard class and checks
// each word the block emits, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_telemetry_history_recorder;
  import thr_pkg::*;

  localparam int unsigned RingDepth    = 20;
  // A tick that emits nothing may still be in flight when the last word lands;
  // this covers the longest tick, one with a full ring dump, with margin.
  localparam int unsigned SettleCycles = 40;
  // The limit covers the slowest legal run: 21 words per tick, each behind the
  // longest output stall, plus input gaps, over about 500 ticks, with margin.
  localparam int unsigned CycleLimit   = 1500000;
  localparam int unsigned RandomTicks  = 430;

  // Mode flag combinations, built from the bit positions in the package.
  localparam logic [1:0] ModeNormal     = 2'b00;
  localparam logic [1:0] ModeFault      = 2'(1 << ModeErrorBit);
  localparam logic [1:0] ModeSleep      = 2'(1 << ModeSleepBit);
  localparam logic [1:0] ModeFaultSleep = ModeFault | ModeSleep;

  // One system tick as it is driven onto the input channel.
  typedef struct {
    logic [7:0]  stack;
    logic [8:0]  processor;
    logic [7:0]  ambient;  // two's complement, handled as a raw byte
    logic [15:0] fc_peak;
    logic [15:0] min_fc;
    logic [15:0] battery;
    logic [15:0] air_flow;
    logic [7:0]  fuel;
    logic [15:0] min_out;
    logic [15:0] load_peak;
    logic [15:0] status;
    logic [1:0]  mode;
  } tick_t;

  // One output word: a 22-byte record split over three ports plus flags.
  typedef struct {
    logic [63:0] low;
    logic [63:0] mid;
    logic [47:0] high;
    logic        is_dump;
    logic        last;
  } record_word_t;

  // The scoreboard keeps its own copy of the configuration and of the whole
  // recorder state, including the history ring, and turns every accepted tick
  // into the words it must cause.
  class history_scoreboard;
    logic [7:0]         normal_iv;
    logic [7:0]         sleep_iv;
    logic [6:0]         record_period;
    logic [6:0]         tick_cnt;
    logic [RecordW-1:0] history [RingDepth];
    int unsigned        next_row;
    logic [7:0]         interval;
    logic [7:0]         pending_records;
    logic [SecondsW-1:0] seconds;
    bit                 dump_taken;
    record_word_t       expected_words[$];
    int unsigned        fail_count;
    int unsigned        words_checked;

    function new();
      normal_iv       = 8'd1;
      sleep_iv        = 8'd60;
      record_period   = 7'd100;
      tick_cnt        = '0;
      foreach (history[i]) history[i] = '0;
      next_row        = 0;
      interval        = '0;
      pending_records = '0;
      seconds         = '0;
      dump_taken      = 1'b0;
      fail_count      = 0;
      words_checked   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        CfgNormalInterval: normal_iv = data;
        CfgSleepInterval:  sleep_iv = data;
        CfgTicksPerRecord: record_period = data[6:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function void push_word(logic [RecordW-1:0] rec, bit dump);
      record_word_t w;
      w.low     = rec[63:0];
      w.mid     = rec[127:64];
      w.high    = rec[175:128];
      w.is_dump = dump;
      w.last    = 1'b0;
      expected_words.push_back(w);
    endfunction

    function void note_tick(tick_t t);
      logic [RecordW-1:0] rec;
      int unsigned        row;
      int unsigned        produced;
      record_word_t       tail;
      produced = 0;
      tick_cnt = tick_cnt + 7'd1;
      if (tick_cnt == record_period) begin
        // Byte layout, little endian: interval, stack, processor/2, ambient+50,
        // fc/100, min_fc/10, battery, air flow, fuel, min_out/100,
        // load/100, status, then the 24-bit seconds count.
        rec           = '0;
        rec[7:0]      = interval;
        rec[15:8]     = t.stack;
        rec[23:16]    = t.processor[8:1];
        rec[31:24]    = t.ambient + AmbientOffset;
        rec[47:32]    = t.fc_peak / 16'd100;
        rec[63:48]    = t.min_fc / 16'd10;
        rec[79:64]    = t.battery;
        rec[95:80]    = t.air_flow;
        rec[103:96]   = t.fuel;
        rec[119:104]  = t.min_out / 16'd100;
        rec[135:120]  = t.load_peak / 16'd100;
        rec[151:136]  = t.status;
        seconds = seconds + 1'b1;
        if (seconds >= SecondsWrap) seconds = '0;
        rec[175:152]  = seconds;
        history[next_row] = rec;
        next_row = (next_row + 1) % RingDepth;
        tick_cnt = '0;
        pending_records = pending_records + 8'd1;
        if (pending_records >= interval) begin
          push_word(rec, 1'b0);
          produced++;
          pending_records = '0;
        end
      end
      // The mode flags are looked at on every tick, captured record or not.
      if (t.mode[ModeErrorBit] && !t.mode[ModeSleepBit]) begin
        interval = ErrorInterval;
        if (!dump_taken) begin
          // Oldest row first: the row about to be overwritten next.
          row = next_row;
          repeat (RingDepth) begin
            rec = history[row];
            rec[7:0] = DumpByte0;
            push_word(rec, 1'b1);
            produced++;
            row = (row + 1) % RingDepth;
          end
          dump_taken = 1'b1;
        end
      end else begin
        interval = t.mode[ModeSleepBit] ? sleep_iv : normal_iv;
        dump_taken = 1'b0;
      end
      if (produced > 0) begin
        tail = expected_words.pop_back();
        tail.last = 1'b1;
        expected_words.push_back(tail);
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %h, got %h", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_word(record_word_t got);
      record_word_t want;
      words_checked++;
      if (expected_words.size() == 0) begin
        $error("record word with nothing expected: low %h mid %h high %h",
               got.low, got.mid, got.high);
        fail_count++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("record_low", want.low, got.low);
      compare_field("record_mid", want.mid, got.mid);
      compare_field("record_high", 64'(want.high), 64'(got.high));
      compare_field("is_dump", 64'(want.is_dump), 64'(got.is_dump));
      compare_field("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  stack_temp_i;
  logic [8:0]  processor_temp_i;
  logic signed [7:0] ambient_temp_i;
  logic [15:0] fc_peak_current_i;
  logic [15:0] min_fc_volts_i;
  logic [15:0] battery_centivolts_i;
  logic [15:0] air_flow_tenths_i;
  logic [7:0]  fuel_flow_i;
  logic [15:0] min_output_volts_i;
  logic [15:0] load_peak_current_i;
  logic [15:0] status_bytes_i;
  logic [1:0]  mode_flags_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] record_low_o;
  logic [63:0] record_mid_o;
  logic [47:0] record_high_o;
  logic        is_dump_o;
  logic        last_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;

  history_scoreboard sb = new();
  // When set, neither side idles: the input streams back to back and the
  // output is always ready.
  bit           relaxed = 1'b0;
  int unsigned  random_ticks = 0;
  int unsigned  cycle_count = 0;
  int unsigned  stall_left = 0;
  record_word_t observed;

  telemetry_history_recorder #(
    .RING_DEPTH(RingDepth)
  ) u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .stack_temp_i        (stack_temp_i),
    .processor_temp_i    (processor_temp_i),
    .ambient_temp_i      (ambient_temp_i),
    .fc_peak_current_i   (fc_peak_current_i),
    .min_fc_volts_i      (min_fc_volts_i),
    .battery_centivolts_i(battery_centivolts_i),
    .air_flow_tenths_i   (air_flow_tenths_i),
    .fuel_flow_i         (fuel_flow_i),
    .min_output_volts_i  (min_output_volts_i),
    .load_peak_current_i (load_peak_current_i),
    .status_bytes_i      (status_bytes_i),
    .mode_flags_i        (mode_flags_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .record_low_o        (record_low_o),
    .record_mid_o        (record_mid_o),
    .record_high_o       (record_high_o),
    .is_dump_o           (is_dump_o),
    .last_o              (last_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop in case the block hangs or loses words.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one; none at all when relaxed.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (relaxed || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  // Output back-pressure. Each edge either continues a stall or grants one
  // cycle of ready and draws the length of the next stall.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Output values are sampled at the edge, before the block updates them.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      observed.low     = record_low_o;
      observed.mid     = record_mid_o;
      observed.high    = record_high_o;
      observed.is_dump = is_dump_o;
      observed.last    = last_o;
      sb.check_word(observed);
    end
  end

  function automatic tick_t random_tick(logic [1:0] mode);
    tick_t t;
    t.stack     = 8'($urandom);
    t.processor = 9'($urandom);
    t.ambient   = 8'($urandom);
    t.fc_peak   = 16'($urandom);
    t.min_fc    = 16'($urandom);
    t.battery   = 16'($urandom);
    t.air_flow  = 16'($urandom);
    t.fuel      = 8'($urandom);
    t.min_out   = 16'($urandom);
    t.load_peak = 16'($urandom);
    t.status    = 16'($urandom);
    t.mode      = mode;
    return t;
  endfunction

  // Every field at all zeros or all ones.
  function automatic tick_t flat_tick(bit ones, logic [1:0] mode);
    tick_t t;
    t.stack     = {8{ones}};
    t.processor = {9{ones}};
    t.ambient   = {8{ones}};
    t.fc_peak   = {16{ones}};
    t.min_fc    = {16{ones}};
    t.battery   = {16{ones}};
    t.air_flow  = {16{ones}};
    t.fuel      = {8{ones}};
    t.min_out   = {16{ones}};
    t.load_peak = {16{ones}};
    t.status    = {16{ones}};
    t.mode      = mode;
    return t;
  endfunction

  // Modes come in runs, so that error episodes last several ticks, end,
  // and start again, which re-arms and fires the dump.
  function automatic logic [1:0] next_mode(logic [1:0] cur);
    int unsigned r;
    if ($urandom_range(0, 4) != 0) return cur;
    r = $urandom_range(0, 99);
    if (r < 40) return ModeNormal;
    if (r < 65) return ModeFault;
    if (r < 85) return ModeSleep;
    return ModeFaultSleep;
  endfunction

  function automatic logic [7:0] pick_interval();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'($urandom_range(0, 2));
    if (r < 50) return ErrorInterval;
    if (r < 80) return 8'($urandom_range(0, 10));
    return 8'($urandom);
  endfunction

  // Mostly short periods so that records are frequent. Bit 7 of the data is
  // not part of the register and is set at random.
  function automatic logic [7:0] pick_period();
    logic [7:0] v;
    v = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(1, 4)) : 8'($urandom_range(5, 127));
    v[7] = 1'($urandom);
    return v;
  endfunction

  task automatic pause_input(input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Presents one tick, holds it until it is taken, then idles for a random gap, which may be zero.
  task automatic send_tick(input tick_t t);
    in_valid_i           <= 1'b1;
    stack_temp_i         <= t.stack;
    processor_temp_i     <= t.processor;
    ambient_temp_i       <= t.ambient;
    fc_peak_current_i    <= t.fc_peak;
    min_fc_volts_i       <= t.min_fc;
    battery_centivolts_i <= t.battery;
    air_flow_tenths_i    <= t.air_flow;
    fuel_flow_i          <= t.fuel;
    min_output_volts_i   <= t.min_out;
    load_peak_current_i  <= t.load_peak;
    status_bytes_i       <= t.status;
    mode_flags_i         <= t.mode;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_tick(t);
    pause_input(pick_gap());
  endtask

  // Leaves cfg_valid_i high so that writes can follow back to back.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input logic [7:0] normal_iv, input logic [7:0] sleep_iv,
                           input logic [7:0] period);
    write_reg(CfgNormalInterval, normal_iv);
    write_reg(CfgSleepInterval, sleep_iv);
    write_reg(CfgTicksPerRecord, period);
    cfg_valid_i <= 1'b0;
  endtask

  // Stops the input and waits until every predicted word has come out. The
  // loop waits for a clock edge before it checks, so a following tick never
  // re-raises valid in the same step in which it was dropped.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() > 0);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One configuration setting followed by a run of random ticks. With hold
  // set, the input pauses halfway until the output has fully drained.
  task automatic run_phase(input logic [7:0] normal_iv, input logic [7:0] sleep_iv,
                           input logic [7:0] period, input int unsigned ticks,
                           input bit hold);
    logic [1:0] mode;
    settle();
    configure(normal_iv, sleep_iv, period);
    relaxed = ($urandom_range(0, 3) == 0);
    mode = ModeNormal;
    for (int unsigned i = 0; i < ticks; i++) begin
      if (hold && i == ticks / 2) wait_drained();
      mode = next_mode(mode);
      send_tick(random_tick(mode));
      random_ticks++;
    end
  endtask

  initial begin
    tick_t       tk;
    in_valid_i           <= 1'b0;
    stack_temp_i         <= '0;
    processor_temp_i     <= '0;
    ambient_temp_i       <= '0;
    fc_peak_current_i    <= '0;
    min_fc_volts_i       <= '0;
    battery_centivolts_i <= '0;
    air_flow_tenths_i    <= '0;
    fuel_flow_i          <= '0;
    min_output_volts_i   <= '0;
    load_peak_current_i  <= '0;
    status_bytes_i       <= '0;
    mode_flags_i         <= ModeNormal;
    cfg_valid_i          <= 1'b0;
    cfg_index_i          <= CfgNormalInterval;
    cfg_data_i           <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. One record per tick, intervals left at their reset values.
    configure(8'd1, 8'd60, 8'd1);
    // The first record carries the reset interval of zero and is always emitted.
    send_tick(flat_tick(1'b0, ModeNormal));
    send_tick(flat_tick(1'b1, ModeNormal));
    // Odd processor value, most negative ambient, quotients just below a step, min_out on one.
    tk = random_tick(ModeNormal);
    tk.ambient   = 8'h80;
    tk.processor = 9'd1;
    tk.fc_peak   = 16'd99;
    tk.min_fc    = 16'd9;
    tk.min_out   = 16'd100;
    tk.load_peak = 16'd199;
    send_tick(tk);
    // Most positive ambient and quotients exactly on a step, min_out just below one.
    tk = random_tick(ModeNormal);
    tk.ambient   = 8'h7F;
    tk.fc_peak   = 16'd100;
    tk.min_fc    = 16'd10;
    tk.min_out   = 16'd99;
    tk.load_peak = 16'd100;
    send_tick(tk);
    // An ambient of -50 packs to zero.
    tk = random_tick(ModeNormal);
    tk.ambient = 8'hCE;
    send_tick(tk);
    // First error tick: the dump includes rows that were never written.
    send_tick(random_tick(ModeFault));
    // Staying in error paces records at the error interval, with no new dump.
    repeat (6) send_tick(random_tick(ModeFault));
    send_tick(flat_tick(1'b1, ModeFault));
    // Error while sleeping counts as sleep and re-arms the dump.
    send_tick(random_tick(ModeFaultSleep));
    repeat (2) send_tick(random_tick(ModeSleep));
    send_tick(random_tick(ModeFault));
    repeat (2) send_tick(random_tick(ModeNormal));

    // Extreme settings first: interval zero with the widest sleep interval,
    // the reverse, the longest period, and a period of zero (written with the
    // unused top bit set), which only matches once the tick count wraps.
    run_phase(8'd0, 8'd255, 8'd1, 40, 1'b1);
    run_phase(8'd255, 8'd0, 8'd2, 40, 1'b0);
    run_phase(8'd1, 8'd2, 8'd127, 130, 1'b0);
    run_phase(8'd1, 8'd1, 8'h80, 130, 1'b0);
    // Random settings; a lowered period can leave the tick count past it,
    // which the predictor follows through the wrap.
    while (random_ticks < RandomTicks) begin
      run_phase(pick_interval(), pick_interval(), pick_period(), $urandom_range(15, 45),
                $urandom_range(0, 3) == 0);
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
